// ===== rtl/cdq_pkg.sv =====
// ============================================================================
// cdq_pkg
// Shared types, widths and codes for the circular deque block.
// ============================================================================
`default_nettype none

package cdq_pkg;

    // Default number of words held by the deque.
    localparam int DEPTH_DEF = 16;

    // Fixed field widths of the item and result beats.
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an item beat is taken this cycle
        logic finish;   // the RAM read of a pop is returned this cycle
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read; // the offered item is a pop that leaves words behind
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/cdq_ram.sv =====
// ============================================================================
// cdq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// ============================================================================
// cdq_ctrl
// Handshake controller: accepts item beats, sequences the pop read and owns
// the result valid flag.
// ============================================================================
`default_nettype none

module cdq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  wire logic              i_stall,
    input  wire cdq_pkg::t_dp_stat i_stat,
    output cdq_pkg::t_ctl_cmd      o_cmd
);
    import cdq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;
    logic accept;

    // The result register can take a new result when empty or draining now.
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.need_read) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cmd.accept  = accept;
    assign o_cmd.finish  = (r_state == S_READ);

    // The result register has always drained before a pop read returns.
    a_read_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("pop read returned while a result was still held");

    // A pop that needs a read finishes in the cycle after it is accepted.
    a_read_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_stat.need_read) |=> (o_cmd.finish && o_valid == 1'b0))
        else $error("pop read did not finish in the following cycle");

    // A held result that is stalled keeps the item side stalled.
    a_held_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> o_stall)
        else $error("item beat taken while a stalled result was held");

endmodule

`default_nettype wire

// ===== rtl/cdq_datapath.sv =====
// ============================================================================
// cdq_datapath
// Indices, word count, cached end words and the circular word store.
// ============================================================================
`default_nettype none

module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cdq_pkg::t_ctl_cmd             i_cmd,
    output cdq_pkg::t_dp_stat                  o_stat,
    input  wire logic [cdq_pkg::OP_W-1:0]      i_operation,
    input  wire logic [cdq_pkg::DATA_W-1:0]    i_value,
    output logic      [cdq_pkg::ST_W-1:0]      o_status,
    output logic      [cdq_pkg::DATA_W-1:0]    o_popped_value,
    output logic      [cdq_pkg::DATA_W-1:0]    o_front_value,
    output logic      [cdq_pkg::DATA_W-1:0]    o_rear_value,
    output logic                               o_is_empty,
    output logic                               o_is_full,
    output logic      [cdq_pkg::OCC_W-1:0]     o_occupancy
);
    import cdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_rear, n_rear;
    logic              r_fill_rear, n_fill_rear;
    logic [ST_W-1:0]   r_status, n_status;
    logic [DATA_W-1:0] r_popped, n_popped;

    logic [IW-1:0]     head_inc, head_dec, tail_inc, tail_dec;
    logic              is_push, empty, full;
    logic              wr_en;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] rd_data;

    assign head_inc = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? IW'(DEPTH - 1) : r_head - 1'b1;
    assign tail_inc = (r_tail == IW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? IW'(DEPTH - 1) : r_tail - 1'b1;

    assign is_push = (i_operation == OP_PUSH_FRONT) || (i_operation == OP_PUSH_REAR);
    assign empty   = (r_count == '0);
    assign full    = (r_count == CW'(DEPTH));

    // A pop from two or more words must fetch the new end word from the store.
    assign o_stat.need_read = !is_push && (r_count > CW'(1));

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_rear      = r_rear;
        n_fill_rear = r_fill_rear;
        n_status    = r_status;
        n_popped    = r_popped;
        wr_en       = 1'b0;
        wr_addr     = r_head;
        rd_addr     = head_inc;
        if (i_cmd.accept) begin
            n_status = ST_OK;
            n_popped = '0;
            if (is_push) begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (empty) begin
                        n_head  = '0;
                        n_tail  = '0;
                        wr_addr = '0;
                        n_front = i_value;
                        n_rear  = i_value;
                    end else if (i_operation == OP_PUSH_FRONT) begin
                        n_head  = head_dec;
                        wr_addr = head_dec;
                        n_front = i_value;
                    end else begin
                        n_tail  = tail_inc;
                        wr_addr = tail_inc;
                        n_rear  = i_value;
                    end
                end
            end else begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count = r_count - 1'b1;
                    if (i_operation == OP_POP_FRONT) begin
                        n_popped    = r_front;
                        n_head      = head_inc;
                        rd_addr     = head_inc;
                        n_fill_rear = 1'b0;
                    end else begin
                        n_popped    = r_rear;
                        n_tail      = tail_dec;
                        rd_addr     = tail_dec;
                        n_fill_rear = 1'b1;
                    end
                    // Removing the last word puts both indices back at the start.
                    if (r_count == CW'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
            end
        end
        if (i_cmd.finish) begin
            if (r_fill_rear) begin
                n_rear = rd_data;
            end else begin
                n_front = rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front     <= n_front;
        r_rear      <= n_rear;
        r_fill_rear <= n_fill_rear;
        r_status    <= n_status;
        r_popped    <= n_popped;
    end

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_front_value  = empty ? '0 : r_front;
    assign o_rear_value   = empty ? '0 : r_rear;
    assign o_is_empty     = empty;
    assign o_is_full      = full;
    assign o_occupancy    = OCC_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("word count exceeds the depth");

    a_empty_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("indices not at the start while empty");

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(1)) |-> (r_head == r_tail))
        else $error("head and tail differ with a single word held");

endmodule

`default_nettype wire

// ===== rtl/circular_deque.sv =====
// ============================================================================
// circular_deque
// Double-ended queue of 32-bit words on a circular store with push and pop
// at both ends, reporting status, end words and occupancy for every beat.
// ============================================================================
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+------------------------------
//   item     | in        | i_valid / o_stall  | i_operation, i_value
//   result   | out       | o_valid / i_stall  | o_status, o_popped_value,
//            |           |                    | o_front_value, o_rear_value,
//            |           |                    | o_is_empty, o_is_full,
//            |           |                    | o_occupancy
//
// Pushes, overflows, underflows and pops that empty the deque reach the result
// register in the cycle after the item beat. A pop that leaves words behind
// passes through the read state first, since the new end word comes from the
// store through its registered read port; items are therefore taken one at a
// time, one per cycle while no pop read is pending and no result is stalled.
// Reset is synchronous and active low, clears the indices and word count, and
// needs no sweep of the store. A held, stalled result stalls the item side;
// a result being taken in the same cycle frees the block for a new item beat.
//
`default_nettype none

module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Item channel.
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic        [cdq_pkg::OP_W-1:0]     i_operation,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]   i_value,
    // Result channel.
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic             [cdq_pkg::ST_W-1:0]     o_status,
    output logic signed      [cdq_pkg::DATA_W-1:0]   o_popped_value,
    output logic signed      [cdq_pkg::DATA_W-1:0]   o_front_value,
    output logic signed      [cdq_pkg::DATA_W-1:0]   o_rear_value,
    output logic                                     o_is_empty,
    output logic                                     o_is_full,
    output logic             [cdq_pkg::OCC_W-1:0]    o_occupancy
);
    import cdq_pkg::*;

    t_ctl_cmd          cmd;
    t_dp_stat          stat;
    logic [DATA_W-1:0] value_bits;
    logic [DATA_W-1:0] popped_bits;
    logic [DATA_W-1:0] front_bits;
    logic [DATA_W-1:0] rear_bits;

    // The controller owns both handshakes and tells the datapath when a beat
    // is taken and when a pending store read has returned.
    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Words travel as raw bits inside; the signed view is kept at the ports.
    assign value_bits = DATA_W'(i_value);

    // The datapath keeps the indices, the count, a copy of the front and rear
    // words, and the store itself. Its result fields stay stable until the
    // next item beat, which cannot come while a result is stalled.
    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_value        (value_bits),
        .o_status       (o_status),
        .o_popped_value (popped_bits),
        .o_front_value  (front_bits),
        .o_rear_value   (rear_bits),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_occupancy    (o_occupancy)
    );

    assign o_popped_value = signed'(popped_bits);
    assign o_front_value  = signed'(front_bits);
    assign o_rear_value   = signed'(rear_bits);

endmodule

`default_nettype wire
